@@ rtl/mcg_pkg.sv @@
`default_nettype none
package mcg_pkg;

  // field widths
  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 6;
  localparam int OUT_BITS    = 12;

  // walk arithmetic widths: x and y offsets, decision variable
  localparam int STEP_BITS = RADIUS_BITS + 2;
  localparam int D_BITS    = RADIUS_BITS + 6;

  // guard on the number of beats per circle
  localparam int MAX_RES  = 48;
  localparam int CNT_BITS = $clog2(MAX_RES);

  // request queue between front and walker
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] circle_radius;
  } req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cx_plus_x;
    logic signed [OUT_BITS-1:0] cx_minus_x;
    logic signed [OUT_BITS-1:0] cx_plus_y;
    logic signed [OUT_BITS-1:0] cx_minus_y;
    logic signed [OUT_BITS-1:0] cy_plus_y;
    logic signed [OUT_BITS-1:0] cy_minus_y;
    logic signed [OUT_BITS-1:0] cy_plus_x;
    logic signed [OUT_BITS-1:0] cy_minus_x;
    logic                       last_step;
  } res_t;

  // prepared circle job: centre, radius and starting decision value
  typedef struct packed {
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] r;
    logic [D_BITS-1:0]      d0;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  typedef struct packed {
    logic busy;
    logic load;
  } walk_stat_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

endpackage
`default_nettype wire

@@ rtl/midpoint_circle_generator_unit.sv @@
`default_nettype none
// from an accepted request to its first result beat, a job passes through
// the front register, queue, walker load and output register, in that order
// throughput: one result beat per cycle while out_stall is low; a circle of
// n beats, n running from 2 (radius 0) to about 46, holds the walker busy
// reset: synchronous active-low rst_n empties front, queue, walker and output
module midpoint_circle_generator_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mcg_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mcg_pkg::res_t      out_data
);
  import mcg_pkg::*;

  job_chan_t             push;
  job_chan_t             head;
  logic                  q_full;
  logic                  pop;
  logic [Q_CNT_BITS-1:0] q_cnt;
  walk_stat_t            stat;

  // request preparation
  mcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  // job queue
  mcg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .q_full (q_full),
    .head   (head),
    .q_cnt  (q_cnt)
  );

  // decision-variable walker
  mcg_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= Q_CNT_BITS'(Q_DEPTH))
    else $error("queue count beyond depth");

  // the walker only loads from a non-empty queue while idle
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load |-> (q_cnt != '0) && !stat.busy)
    else $error("walker load without a queued job");

  // a circle ends only with its last beat in the output register
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.busy) |-> out_valid && out_data.last_step)
    else $error("walk ended without a last beat");
`endif

endmodule
`default_nettype wire

@@ rtl/mcg_front.sv @@
`default_nettype none
module mcg_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mcg_pkg::req_t in_data,
  input  wire logic          q_full,
  output mcg_pkg::job_chan_t push
);
  import mcg_pkg::*;

  logic fr_valid_r, fr_valid_nxt;
  job_t fr_job_r, fr_job_nxt;
  logic accept;
  logic push_ok;

  // hand the held job on whenever the queue has room
  assign push_ok  = fr_valid_r && !q_full;
  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  assign push.valid = push_ok;
  assign push.job   = fr_job_r;

  // prepare the job: starting decision value 3 - 2r
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_job_nxt   = fr_job_r;
    if (accept) begin
      fr_valid_nxt   = 1'b1;
      fr_job_nxt.cx  = in_data.center_x;
      fr_job_nxt.cy  = in_data.center_y;
      fr_job_nxt.r   = in_data.circle_radius;
      fr_job_nxt.d0  = D_BITS'(3) -
                       ({{(D_BITS-RADIUS_BITS){1'b0}}, in_data.circle_radius} << 1);
    end else if (push_ok) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_job_r <= fr_job_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/mcg_queue.sv @@
`default_nettype none
module mcg_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mcg_pkg::job_chan_t push,
  input  wire logic               pop,
  output logic                    q_full,
  output mcg_pkg::job_chan_t      head,
  output logic [mcg_pkg::Q_CNT_BITS-1:0] q_cnt
);
  import mcg_pkg::*;

  job_t                  slot_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign q_full     = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = slot_r[rd_ptr_r];
  assign q_cnt      = cnt_r;

  assign do_push = push.valid && !q_full;
  assign do_pop  = pop && head.valid;

  // pointer wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.job;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcg_walk.sv @@
`default_nettype none
module mcg_walk (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mcg_pkg::job_chan_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mcg_pkg::res_t           out_data,
  output mcg_pkg::walk_stat_t     stat
);
  import mcg_pkg::*;

  walk_state_t state_r, state_nxt;

  logic [STEP_BITS-1:0]  x_r, x_nxt;
  logic [STEP_BITS-1:0]  y_r, y_nxt;
  logic [D_BITS-1:0]     d_r, d_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_data_r, out_data_nxt;

  logic                  out_free;
  logic                  emit;
  logic                  more;
  logic                  d_le0;
  logic [OUT_BITS-1:0]   x_o, y_o, cx_o, cy_o;
  logic [D_BITS-1:0]     x_d, y_d;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == WALK_RUN) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // another step follows while x <= y, capped at the beat guard
  assign more = ($signed({1'b0, x_r}) <= $signed({y_r[STEP_BITS-1], y_r})) &&
                (cnt_r != CNT_BITS'(MAX_RES-1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WALK_IDLE: begin
        if (head.valid) begin
          state_nxt = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (emit && !more) begin
          state_nxt = WALK_IDLE;
        end
      end
      default: state_nxt = WALK_IDLE;
    endcase
  end

  assign pop        = (state_r == WALK_IDLE) && head.valid;
  assign stat.busy  = (state_r == WALK_RUN);
  assign stat.load  = pop;

  // symmetric coordinates, wrapped to the output width
  assign x_o  = {{(OUT_BITS-STEP_BITS){1'b0}}, x_r};
  assign y_o  = {{(OUT_BITS-STEP_BITS){y_r[STEP_BITS-1]}}, y_r};
  assign cx_o = {{(OUT_BITS-COORD_BITS){1'b0}}, cx_r};
  assign cy_o = {{(OUT_BITS-COORD_BITS){1'b0}}, cy_r};

  // decision update terms
  assign x_d   = {{(D_BITS-STEP_BITS){1'b0}}, x_r};
  assign y_d   = {{(D_BITS-STEP_BITS){y_r[STEP_BITS-1]}}, y_r};
  assign d_le0 = d_r[D_BITS-1] || (d_r == '0);

  // walk datapath and output register
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      x_nxt   = '0;
      y_nxt   = {{(STEP_BITS-RADIUS_BITS){1'b0}}, head.job.r};
      d_nxt   = head.job.d0;
      cx_nxt  = head.job.cx;
      cy_nxt  = head.job.cy;
      cnt_nxt = '0;
    end
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.cx_plus_x  = cx_o + x_o;
      out_data_nxt.cx_minus_x = cx_o - x_o;
      out_data_nxt.cx_plus_y  = cx_o + y_o;
      out_data_nxt.cx_minus_y = cx_o - y_o;
      out_data_nxt.cy_plus_y  = cy_o + y_o;
      out_data_nxt.cy_minus_y = cy_o - y_o;
      out_data_nxt.cy_plus_x  = cy_o + x_o;
      out_data_nxt.cy_minus_x = cy_o - x_o;
      out_data_nxt.last_step  = !more;
      if (more) begin
        if (d_le0) begin
          d_nxt = d_r + (x_d << 2) + D_BITS'(6);
        end else begin
          d_nxt = d_r + ((x_d - y_d) << 2) + D_BITS'(10);
          y_nxt = y_r - 1'b1;
        end
        x_nxt   = x_r + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WALK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    d_r        <= d_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ tb/tb_midpoint_circle_generator_unit.sv @@
module tb_midpoint_circle_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcg_pkg::*;

  localparam int RANDOM_CIRCLES = 104;
  localparam int IDLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES   = 16;

  // one directed request; typed rows carry both beats of a zero-radius circle
  typedef struct packed {
    req_t req;
    bit   typed;
    res_t first_pt;
    res_t last_pt;
  } circle_row_t;

  localparam res_t NO_POINT = '0;

  localparam circle_row_t DIRECTED_ROWS [17] = '{
    // zero radius in all four corners
    '{'{10'd0, 10'd0, 6'd0}, 1'b1,
      '{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0},
      '{12'sd1, -12'sd1, -12'sd1, 12'sd1, -12'sd1, 12'sd1, 12'sd1, -12'sd1, 1'b1}},
    '{'{10'd1023, 10'd1023, 6'd0}, 1'b1,
      '{12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023,
        12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023, 1'b0},
      '{12'sd1024, 12'sd1022, 12'sd1022, 12'sd1024,
        12'sd1022, 12'sd1024, 12'sd1024, 12'sd1022, 1'b1}},
    '{'{10'd0, 10'd1023, 6'd0}, 1'b1,
      '{12'sd0, 12'sd0, 12'sd0, 12'sd0,
        12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023, 1'b0},
      '{12'sd1, -12'sd1, -12'sd1, 12'sd1,
        12'sd1022, 12'sd1024, 12'sd1024, 12'sd1022, 1'b1}},
    '{'{10'd1023, 10'd0, 6'd0}, 1'b1,
      '{12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023,
        12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0},
      '{12'sd1024, 12'sd1022, 12'sd1022, 12'sd1024,
        -12'sd1, 12'sd1, 12'sd1, -12'sd1, 1'b1}},
    // largest radius in the corners, negative and overshooting coordinates
    '{'{10'd0, 10'd0, 6'd63}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd1023, 10'd1023, 6'd63}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd0, 10'd1023, 6'd63}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd1023, 10'd0, 6'd63}, 1'b0, NO_POINT, NO_POINT},
    // small radii, alternating bit patterns and other mixed centres and radii
    '{'{10'd512, 10'd512, 6'd1}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd512, 10'd512, 6'd2}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd3, 10'd7, 6'd3}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'h2AA, 10'h155, 6'h2A}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'h155, 10'h2AA, 6'h15}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd1000, 10'd20, 6'd62}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd100, 10'd900, 6'd31}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd900, 10'd100, 6'd32}, 1'b0, NO_POINT, NO_POINT},
    '{'{10'd7, 10'd7, 6'd63}, 1'b0, NO_POINT, NO_POINT}
  };

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  // predictor state, as left by the last walk
  logic [COORD_BITS-1:0] held_cx;
  logic [COORD_BITS-1:0] held_cy;
  logic [6:0]            walk_x;
  logic signed [7:0]     walk_y;
  logic signed [9:0]     walk_d;

  res_t expected_points[$];
  int   mismatch_count = 0;
  int   stall_left     = 0;
  int   beats_taken    = 0;
  int   idle_cycles    = 0;

  midpoint_circle_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // eight symmetric coordinates of one walk point, wrapped to the output width
  function automatic res_t make_point(input int x, input int y);
    res_t pt;
    int   cx;
    int   cy;
    cx = int'(held_cx);
    cy = int'(held_cy);
    pt.cx_plus_x  = OUT_BITS'(cx + x);
    pt.cx_minus_x = OUT_BITS'(cx - x);
    pt.cx_plus_y  = OUT_BITS'(cx + y);
    pt.cx_minus_y = OUT_BITS'(cx - y);
    pt.cy_plus_y  = OUT_BITS'(cy + y);
    pt.cy_minus_y = OUT_BITS'(cy - y);
    pt.cy_plus_x  = OUT_BITS'(cy + x);
    pt.cy_minus_x = OUT_BITS'(cy - x);
    pt.last_step  = 1'b0;
    return pt;
  endfunction

  // decision-variable walk of one circle; queues its beats unless the row types them
  function automatic void walk_circle(input req_t req, input bit typed_row);
    res_t pts[$];
    res_t pt;
    int   x;
    int   y;
    int   d;
    held_cx = req.center_x;
    held_cy = req.center_y;
    x = 0;
    y = int'(req.circle_radius);
    d = 3 - 2 * y;
    pts.push_back(make_point(x, y));
    while (x <= y && pts.size() < MAX_RES) begin
      if (d <= 0) begin
        d += 4 * x + 6;
      end else begin
        d += 4 * (x - y) + 10;
        y--;
      end
      x++;
      pts.push_back(make_point(x, y));
    end
    pt = pts.pop_back();
    pt.last_step = 1'b1;
    pts.push_back(pt);
    walk_x = 7'(x);
    walk_y = 8'(y);
    walk_d = 10'(d);
    if (!typed_row) begin
      foreach (pts[k]) expected_points.push_back(pts[k]);
    end
  endfunction

  task automatic compare_point(input res_t want, input res_t got);
    if (got.cx_plus_x !== want.cx_plus_x) begin
      $error("cx_plus_x: expected %0d, got %0d", want.cx_plus_x, got.cx_plus_x);
      mismatch_count++;
    end
    if (got.cx_minus_x !== want.cx_minus_x) begin
      $error("cx_minus_x: expected %0d, got %0d", want.cx_minus_x, got.cx_minus_x);
      mismatch_count++;
    end
    if (got.cx_plus_y !== want.cx_plus_y) begin
      $error("cx_plus_y: expected %0d, got %0d", want.cx_plus_y, got.cx_plus_y);
      mismatch_count++;
    end
    if (got.cx_minus_y !== want.cx_minus_y) begin
      $error("cx_minus_y: expected %0d, got %0d", want.cx_minus_y, got.cx_minus_y);
      mismatch_count++;
    end
    if (got.cy_plus_y !== want.cy_plus_y) begin
      $error("cy_plus_y: expected %0d, got %0d", want.cy_plus_y, got.cy_plus_y);
      mismatch_count++;
    end
    if (got.cy_minus_y !== want.cy_minus_y) begin
      $error("cy_minus_y: expected %0d, got %0d", want.cy_minus_y, got.cy_minus_y);
      mismatch_count++;
    end
    if (got.cy_plus_x !== want.cy_plus_x) begin
      $error("cy_plus_x: expected %0d, got %0d", want.cy_plus_x, got.cy_plus_x);
      mismatch_count++;
    end
    if (got.cy_minus_x !== want.cy_minus_x) begin
      $error("cy_minus_x: expected %0d, got %0d", want.cy_minus_x, got.cy_minus_x);
      mismatch_count++;
    end
    if (got.last_step !== want.last_step) begin
      $error("last_step: expected %0d, got %0d", want.last_step, got.last_step);
      mismatch_count++;
    end
  endtask

  // present one request after a gap and hold it until the beat is taken
  task automatic send_request(input req_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side: check each beat, then draw a random stall, none within every third stretch of 50 beats
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data);
          mismatch_count++;
        end else begin
          compare_point(expected_points.pop_front(), out_data);
        end
        beats_taken++;
        stall_left = ((beats_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("midpoint_circle_generator_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t req;
    bit   quiet;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, first rows back to back
    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].req, (i < 4) ? 0 : $urandom_range(0, 7));
      walk_circle(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed);
      if (DIRECTED_ROWS[i].typed) begin
        expected_points.push_back(DIRECTED_ROWS[i].first_pt);
        expected_points.push_back(DIRECTED_ROWS[i].last_pt);
      end
    end

    // let the block drain completely before the random part
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);

    // random circles, every other stretch of 24 with no gaps
    for (int i = 0; i < RANDOM_CIRCLES; i++) begin
      quiet = ((i / 24) % 2 == 1);
      if (i == RANDOM_CIRCLES / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_points.size() != 0);
      end
      req.center_x      = COORD_BITS'($urandom_range(0, 1023));
      req.center_y      = COORD_BITS'($urandom_range(0, 1023));
      req.circle_radius = RADIUS_BITS'($urandom_range(0, 63));
      send_request(req, quiet ? 0 : $urandom_range(0, 7));
      walk_circle(req, 1'b0);
    end
    in_valid <= 1'b0;

    // wait for the last beats, then a short quiet spell
    do @(posedge clk); while (expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("midpoint_circle_generator_unit: match");
    end else begin
      $display("midpoint_circle_generator_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_queue.sv
rtl/mcg_walk.sv
rtl/midpoint_circle_generator_unit.sv
tb/tb_midpoint_circle_generator_unit.sv
